// ===== src/cog_pkg.sv =====
// shared constants, types and helpers for the circle orbit guidance block
package cog_pkg;

  localparam int POS_FRAC_BITS = 8;
  localparam int EPS_D2 = ((1 << (2 * POS_FRAC_BITS)) + 5000000) / 10000000;
  localparam logic [33:0] EPS_RAW = (EPS_D2 == 0) ? 34'd1 : 34'(EPS_D2);
  localparam int CORDIC_ITERS = 16;
  localparam logic signed [40:0] PI_HALF_Q16 = 41'sd102944;
  localparam logic signed [14:0] HEAD_MAX = 15'sd12868;
  localparam int SQRT_STEPS = 25;
  localparam int DIV_STEPS = 42;
  localparam int MUL_BITS = 18;

  typedef enum logic [1:0] {
    ST_RUNNING = 2'd0,
    ST_LAPS    = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_CENTER_X   = 3'd0,
    REG_CENTER_Y   = 3'd1,
    REG_RADIUS     = 3'd2,
    REG_TAN_GAIN   = 3'd3,
    REG_COR_GAIN   = 3'd4,
    REG_TOLERANCE  = 3'd5,
    REG_LAP_TARGET = 3'd6,
    REG_STEP_LIMIT = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_SQRT, PH_DIVX, PH_DIVY, PH_TANX, PH_TANY,
    PH_SQX, PH_SQY, PH_CORX, PH_CORY, PH_DONE
  } phase_t;

  typedef struct packed {
    logic        start;
    logic        busy;
  } unit_ctl_t;

  function automatic logic [17:0] atan_q16(input logic [3:0] i);
    case (i)
      4'd0: atan_q16 = 18'd51472;   4'd1: atan_q16 = 18'd30385;
      4'd2: atan_q16 = 18'd16055;   4'd3: atan_q16 = 18'd8150;
      4'd4: atan_q16 = 18'd4091;    4'd5: atan_q16 = 18'd2047;
      4'd6: atan_q16 = 18'd1024;    4'd7: atan_q16 = 18'd512;
      4'd8: atan_q16 = 18'd256;     4'd9: atan_q16 = 18'd128;
      4'd10: atan_q16 = 18'd64;     4'd11: atan_q16 = 18'd32;
      4'd12: atan_q16 = 18'd16;     4'd13: atan_q16 = 18'd8;
      4'd14: atan_q16 = 18'd4;      4'd15: atan_q16 = 18'd2;
      default: atan_q16 = 18'd0;
    endcase
  endfunction

endpackage

// ===== src/cog_cordic.sv =====
// iterative cordic vectoring unit for the heading, one iteration a cycle
module cog_cordic (
  input  logic               clk,
  input  logic               rst_n,
  input  cog_pkg::unit_ctl_t ctl,
  input  logic signed [16:0] ya,
  input  logic signed [16:0] xa,
  output logic               done,
  output logic signed [14:0] heading
);
  logic signed [40:0] x_r, x_nxt, y_r, y_nxt, z_r, z_nxt;
  logic [3:0]  it_r, it_nxt;
  logic        run_r, run_nxt, zero_r, zero_nxt;
  logic signed [40:0] xs, ys, xa_w, ya_w, zr;
  logic [40:0] zm;

  assign xa_w = 41'(xa) <<< 20;
  assign ya_w = 41'(ya) <<< 20;
  assign xs = x_r >>> it_r;
  assign ys = y_r >>> it_r;

  always_comb begin
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r;
    it_nxt = it_r; run_nxt = run_r; zero_nxt = zero_r;
    if (ctl.start) begin
      zero_nxt = (xa == 0) && (ya == 0);
      it_nxt = '0;
      run_nxt = 1'b1;
      if (xa_w < 0) begin
        if (ya_w >= 0) begin
          x_nxt = ya_w; y_nxt = -xa_w; z_nxt = cog_pkg::PI_HALF_Q16;
        end else begin
          x_nxt = -ya_w; y_nxt = xa_w; z_nxt = -cog_pkg::PI_HALF_Q16;
        end
      end else begin
        x_nxt = xa_w; y_nxt = ya_w; z_nxt = '0;
      end
    end else if (run_r) begin
      if (y_r > 0) begin
        x_nxt = x_r + ys; y_nxt = y_r - xs;
        z_nxt = z_r + 41'(cog_pkg::atan_q16(it_r));
      end else begin
        x_nxt = x_r - ys; y_nxt = y_r + xs;
        z_nxt = z_r - 41'(cog_pkg::atan_q16(it_r));
      end
      it_nxt = it_r + 4'd1;
      if (it_r == 4'(cog_pkg::CORDIC_ITERS - 1)) run_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; it_r <= it_nxt; zero_r <= zero_nxt;
    if (!rst_n) run_r <= 1'b0;
    else run_r <= run_nxt;
  end

  assign done = !run_r;
  always_comb begin
    zm = z_r[40] ? 41'(-z_r) : 41'(z_r);
    zm = (zm + 41'd8) >> 4;
    zr = z_r[40] ? -$signed(zm) : $signed(zm);
    if (zero_r) heading = '0;
    else if (zr > 41'(cog_pkg::HEAD_MAX)) heading = cog_pkg::HEAD_MAX;
    else if (zr < -41'(cog_pkg::HEAD_MAX)) heading = -cog_pkg::HEAD_MAX;
    else heading = 15'(zr);
  end
endmodule

// ===== src/cog_arith.sv =====
// velocity datapath: bit-serial square root, restoring divider and shift-add multiplier
module cog_arith (
  input  logic               clk,
  input  logic               rst_n,
  input  cog_pkg::unit_ctl_t ctl,
  input  logic signed [16:0] ex,
  input  logic signed [16:0] ey,
  input  logic [14:0]        radius,
  input  logic [11:0]        v0,
  input  logic [11:0]        v1,
  output logic               done,
  output logic signed [15:0] vel_x,
  output logic signed [15:0] vel_y
);
  cog_pkg::phase_t ph_r, ph_nxt;
  logic signed [16:0] ex_r, ey_r;
  logic [33:0] d2_r;
  logic [27:0] rem_r;      // sqrt remainder
  logic [25:0] root_r;
  logic [5:0]  cnt_r;
  logic [25:0] dq_r;
  logic [41:0] num_r;
  logic [25:0] drem_r;
  logic [41:0] quo_r;
  logic signed [17:0] rx_r, ry_r;
  logic signed [34:0] seq_r;
  logic [52:0] macc_r;     // product accumulator
  logic [52:0] mcand_r;
  logic [34:0] mplier_r;
  logic        mneg_r;
  logic signed [37:0] tx_r, ty_r, cx_r, cy_r, sq_r;
  logic [33:0] d2_w;
  logic [15:0] ex_m, ey_m;
  logic [33:0] ex2, ey2;
  logic [26:0] trial_rem;
  logic [27:0] trial_sub;
  logic signed [18:0] ratv;
  logic signed [38:0] vxs, vys;
  logic [26:0] dsub;
  logic [52:0] mstep;

  // ex^2 and ey^2 from the 16-bit magnitudes; one narrow multiplier each
  assign ex_m = 16'(ex[16] ? -ex : ex);
  assign ey_m = 16'(ey[16] ? -ey : ey);
  assign ex2 = 34'({16'd0, ex_m} * {16'd0, ex_m});
  assign ey2 = 34'({16'd0, ey_m} * {16'd0, ey_m});

  function automatic logic signed [37:0] rnd_shift(input logic [52:0] m, input logic neg,
                                                   input int s);
    logic [52:0] t;
    t = (m + (53'd1 << (s - 1))) >> s;
    rnd_shift = neg ? -$signed(38'(t)) : $signed(38'(t));
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) ph_r <= cog_pkg::PH_IDLE;
    else ph_r <= ph_nxt;
  end

  always_comb begin
    ph_nxt = ph_r;
    case (ph_r)
      cog_pkg::PH_IDLE: if (ctl.start) ph_nxt = cog_pkg::PH_SQRT;
      cog_pkg::PH_SQRT: if (cnt_r == 6'(cog_pkg::SQRT_STEPS)) ph_nxt = cog_pkg::PH_DIVX;
      cog_pkg::PH_DIVX: if (cnt_r == 6'(cog_pkg::DIV_STEPS)) ph_nxt = cog_pkg::PH_DIVY;
      cog_pkg::PH_DIVY: if (cnt_r == 6'(cog_pkg::DIV_STEPS)) ph_nxt = cog_pkg::PH_TANX;
      cog_pkg::PH_TANX: if (cnt_r == 6'(cog_pkg::MUL_BITS)) ph_nxt = cog_pkg::PH_TANY;
      cog_pkg::PH_TANY: if (cnt_r == 6'(cog_pkg::MUL_BITS)) ph_nxt = cog_pkg::PH_SQX;
      cog_pkg::PH_SQX:  if (cnt_r == 6'(cog_pkg::MUL_BITS)) ph_nxt = cog_pkg::PH_SQY;
      cog_pkg::PH_SQY:  if (cnt_r == 6'(cog_pkg::MUL_BITS)) ph_nxt = cog_pkg::PH_CORX;
      cog_pkg::PH_CORX: if (cnt_r == 6'(cog_pkg::MUL_BITS)) ph_nxt = cog_pkg::PH_CORY;
      cog_pkg::PH_CORY: if (cnt_r == 6'(cog_pkg::MUL_BITS)) ph_nxt = cog_pkg::PH_DONE;
      cog_pkg::PH_DONE: ph_nxt = cog_pkg::PH_IDLE;
      default: ph_nxt = cog_pkg::PH_IDLE;
    endcase
  end

  assign d2_w = ((ex2 + ey2) < cog_pkg::EPS_RAW) ? cog_pkg::EPS_RAW : (ex2 + ey2);
  assign trial_sub = {rem_r[25:0], d2_r[33:32]} - {root_r, 2'b01};
  assign trial_rem = {drem_r, num_r[41]};
  assign dsub = trial_rem - {1'b0, dq_r};
  assign mstep = mplier_r[0] ? macc_r + mcand_r : macc_r;
  assign ratv = (quo_r > 42'd65536) ? 19'sd65536 : $signed(19'(quo_r));

  always_ff @(posedge clk) begin
    case (ph_r)
      cog_pkg::PH_IDLE: begin
        cnt_r <= '0;
        if (ctl.start) begin
          ex_r <= ex;
          ey_r <= ey;
          d2_r <= d2_w;
          rem_r <= '0;
          root_r <= '0;
          seq_r <= 35'(d2_w) - 35'({15'd0, radius} * {15'd0, radius});
        end
      end
      cog_pkg::PH_SQRT: begin
        // radicand d2<<16 is 50 bits, processed two bits a cycle from d2_r's top
        if (cnt_r != 6'(cog_pkg::SQRT_STEPS)) begin
          if (!trial_sub[27]) begin
            rem_r <= trial_sub;
            root_r <= {root_r[24:0], 1'b1};
          end else begin
            rem_r <= {rem_r[25:0], d2_r[33:32]};
            root_r <= {root_r[24:0], 1'b0};
          end
          d2_r <= {d2_r[31:0], 2'b00};
          cnt_r <= cnt_r + 6'd1;
        end else begin
          dq_r <= root_r;
          num_r <= {1'b0, 17'(ex_r[16] ? -ex_r : ex_r), 24'b0} + 42'({1'b0, root_r} >> 1);
          drem_r <= '0; quo_r <= '0; cnt_r <= '0;
        end
      end
      cog_pkg::PH_DIVX, cog_pkg::PH_DIVY: begin
        if (cnt_r != 6'(cog_pkg::DIV_STEPS)) begin
          if (!dsub[26]) begin
            drem_r <= dsub[25:0]; quo_r <= {quo_r[40:0], 1'b1};
          end else begin
            drem_r <= trial_rem[25:0]; quo_r <= {quo_r[40:0], 1'b0};
          end
          num_r <= {num_r[40:0], 1'b0};
          cnt_r <= cnt_r + 6'd1;
        end else begin
          if (ph_r == cog_pkg::PH_DIVX) begin
            rx_r <= ex_r[16] ? 18'(-ratv) : 18'(ratv);
            num_r <= {1'b0, 17'(ey_r[16] ? -ey_r : ey_r), 24'b0} + 42'({1'b0, dq_r} >> 1);
          end else begin
            ry_r <= ey_r[16] ? 18'(-ratv) : 18'(ratv);
            macc_r <= '0; mcand_r <= 53'(v0);
            mplier_r <= 35'(rx_r[17] ? -rx_r : rx_r); mneg_r <= rx_r[17];
          end
          drem_r <= '0; quo_r <= '0; cnt_r <= '0;
        end
      end
      default: begin
        if (ph_r != cog_pkg::PH_DONE && cnt_r != 6'(cog_pkg::MUL_BITS)) begin
          macc_r <= mstep;
          mcand_r <= {mcand_r[51:0], 1'b0};
          mplier_r <= {1'b0, mplier_r[34:1]};
          cnt_r <= cnt_r + 6'd1;
        end else if (ph_r != cog_pkg::PH_DONE) begin
          cnt_r <= '0; macc_r <= '0;
          case (ph_r)
            cog_pkg::PH_TANX: begin
              tx_r <= rnd_shift(macc_r, mneg_r, 16);
              mcand_r <= 53'(v0);
              mplier_r <= 35'(ry_r[17] ? -ry_r : ry_r); mneg_r <= ry_r[17];
            end
            cog_pkg::PH_TANY: begin
              ty_r <= rnd_shift(macc_r, mneg_r, 16);
              mcand_r <= 53'(seq_r[34] ? -seq_r : seq_r);
              mplier_r <= 35'(rx_r[17] ? -rx_r : rx_r);
              mneg_r <= seq_r[34] ^ rx_r[17];
            end
            cog_pkg::PH_SQX: begin
              sq_r <= rnd_shift(macc_r, mneg_r, 16);
              mcand_r <= 53'(seq_r[34] ? -seq_r : seq_r);
              mplier_r <= 35'(ry_r[17] ? -ry_r : ry_r);
              mneg_r <= seq_r[34] ^ ry_r[17];
            end
            cog_pkg::PH_SQY: begin
              cy_r <= rnd_shift(macc_r, mneg_r, 16);
              mcand_r <= 53'(sq_r[37] ? -sq_r : sq_r);
              mplier_r <= 35'(v1); mneg_r <= sq_r[37];
            end
            cog_pkg::PH_CORX: begin
              cx_r <= rnd_shift(macc_r, mneg_r, 2 * cog_pkg::POS_FRAC_BITS);
              mcand_r <= 53'(cy_r[37] ? -cy_r : cy_r);
              mplier_r <= 35'(v1); mneg_r <= cy_r[37];
            end
            default: begin
              cy_r <= rnd_shift(macc_r, mneg_r, 2 * cog_pkg::POS_FRAC_BITS);
            end
          endcase
        end
      end
    endcase
  end

  assign vxs = 39'(ty_r) - 39'(cx_r);
  assign vys = -39'(tx_r) - 39'(cy_r);
  assign vel_x = (vxs > 39'sd32767) ? 16'sh7fff : (vxs < -39'sd32768) ? 16'sh8000 : 16'(vxs);
  assign vel_y = (vys > 39'sd32767) ? 16'sh7fff : (vys < -39'sd32768) ? 16'sh8000 : 16'(vys);
  assign done = (ph_r == cog_pkg::PH_IDLE);
endmodule

// ===== src/circle_orbit_guidance_unit.sv =====
// top level of the circle orbit guidance block
// circle orbit guidance: one position transaction in, one command transaction out
// - in_tdata: pos_x [15:0], pos_y [31:16]
// - out_tdata: vel_x, vel_y, heading, laps_done, status packed from bit 0
// - cfg channel writes register cfg_index with cfg_data; the user must do so only
//   while the block is idle, and the block itself does not enforce it
// the result comes from the sequencer: a 25-step bit-serial square root, two 42-step
// restoring divisions, six 18-bit shift-add multiplies, a done state and the result
// register; the 16-iteration cordic runs beside it
// lap and timeout logic is evaluated in the cycle of acceptance
// in_tready is high only when no item is in work and the output register is free
// reset (rst_n low, synchronous) restores register defaults and clears the task
// a stalled receiver holds out_tvalid and out_tdata until taken
module circle_orbit_guidance_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // pos_x, pos_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // vel_x, vel_y, heading, laps_done, status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic signed [15:0] cx_r, cy_r;
  logic [14:0] rad_r, tol_r;
  logic [11:0] v0_r, v1_r;
  logic [7:0]  lt_r, lap_r, laps_r;
  logic [15:0] sl_r, stp_r;
  logic        lip_r, busy_r, ov_r;
  cog_pkg::status_t st_r;
  logic signed [15:0] vx_r, vy_r;
  logic signed [14:0] hd_r;
  cog_pkg::unit_ctl_t ctl;
  logic signed [16:0] ex, ey;
  logic a_done, c_done;
  logic signed [15:0] a_vx, a_vy;
  logic signed [14:0] c_hd;
  logic acc;
  logic [16:0] ox, oy;
  logic signed [17:0] oxs;
  logic [15:0] tol2;
  logic [15:0] stp_n;
  logic [7:0]  lap_n;
  logic lip_n, run;
  cog_pkg::status_t st_n;

  assign in_tready = !busy_r && !ov_r;
  assign acc = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;
  assign ex = 17'($signed(in_tdata[15:0])) - 17'(cx_r);
  assign ey = 17'($signed(in_tdata[31:16])) - 17'(cy_r);
  assign ctl = '{start: acc, busy: busy_r};

  cog_arith u_arith (.clk, .rst_n, .ctl, .ex, .ey, .radius(rad_r), .v0(v0_r), .v1(v1_r),
                     .done(a_done), .vel_x(a_vx), .vel_y(a_vy));
  cog_cordic u_cordic (.clk, .rst_n, .ctl, .ya(-ex), .xa(ey), .done(c_done), .heading(c_hd));

  // lap logic
  assign oxs = 18'($signed(in_tdata[15:0])) - (18'(cx_r) - 18'({1'b0, rad_r}));
  assign ox = oxs[17] ? 17'(-oxs) : 17'(oxs);
  assign oy = ey[16] ? 17'(-ey) : 17'(ey);
  assign tol2 = {tol_r, 1'b0};
  always_comb begin
    run = (lap_r < lt_r) && (stp_r < sl_r);
    stp_n = stp_r; lap_n = lap_r; lip_n = lip_r;
    if (run) begin
      stp_n = stp_r + 16'd1;
      if (lip_r && ox < 17'(tol_r) && oy < 17'(tol_r)) begin
        if (lap_r != 8'd255) lap_n = lap_r + 8'd1;
        lip_n = 1'b0;
      end
      if (!lip_n && ox > 17'(tol2) && oy > 17'(tol2)) lip_n = 1'b1;
      if (lap_n >= lt_r) st_n = cog_pkg::ST_LAPS;
      else if (stp_n >= sl_r) st_n = cog_pkg::ST_TIMEOUT;
      else st_n = cog_pkg::ST_RUNNING;
    end else begin
      st_n = (lap_r >= lt_r) ? cog_pkg::ST_LAPS : cog_pkg::ST_TIMEOUT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r <= '0; cy_r <= '0; rad_r <= 15'd256; v0_r <= 12'd256; v1_r <= 12'd64;
      tol_r <= 15'd77; lt_r <= 8'd1; sl_r <= 16'd600;
      lap_r <= '0; lip_r <= 1'b0; stp_r <= '0; busy_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cog_pkg::reg_idx_t'(cfg_index))
          cog_pkg::REG_CENTER_X:   cx_r <= cfg_data;
          cog_pkg::REG_CENTER_Y:   cy_r <= cfg_data;
          cog_pkg::REG_RADIUS:     rad_r <= cfg_data[14:0];
          cog_pkg::REG_TAN_GAIN:   v0_r <= cfg_data[11:0];
          cog_pkg::REG_COR_GAIN:   v1_r <= cfg_data[11:0];
          cog_pkg::REG_TOLERANCE:  tol_r <= cfg_data[14:0];
          cog_pkg::REG_LAP_TARGET: lt_r <= cfg_data[7:0];
          cog_pkg::REG_STEP_LIMIT: sl_r <= cfg_data;
          default: ;
        endcase
      end
      if (acc) begin
        busy_r <= 1'b1;
        laps_r <= lap_n;
        st_r <= st_n;
        if (st_n != cog_pkg::ST_RUNNING) begin
          lap_r <= '0; lip_r <= 1'b0; stp_r <= '0;
        end else begin
          lap_r <= lap_n; lip_r <= lip_n; stp_r <= stp_n;
        end
      end else if (busy_r && a_done && c_done) begin
        busy_r <= 1'b0; ov_r <= 1'b1;
        vx_r <= a_vx; vy_r <= a_vy; hd_r <= c_hd;
      end else if (ov_r && out_tready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata = {7'b0, st_r, laps_r, hd_r, vy_r, vx_r};
endmodule

// ===== src/cog_checker.sv =====
// port-level checker for the circle orbit guidance block, with its bind
module cog_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)) else $error("hold");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("overlap");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[56:55] != 2'd3) else $error("status");
  a_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("busy");
endmodule

bind circle_orbit_guidance_unit cog_checker u_chk (.clk, .rst_n, .in_tvalid, .in_tready,
  .out_tvalid, .out_tready, .out_tdata);
